// ----- hw/rtl/route_longest_prefix_match_core_defines.svh -----
// assertion macros for the route lookup core
`ifndef ROUTE_LONGEST_PREFIX_MATCH_CORE_DEFINES_SVH
`define ROUTE_LONGEST_PREFIX_MATCH_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define RLPM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define RLPM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/rlpm_pkg.sv -----
// shared types and codes for the route lookup core
`default_nettype none

package rlpm_pkg;

   localparam int ADDR_W  = 32;
   localparam int PORT_W  = 4;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // one routing table entry
   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
   } entry_type;

   // best candidate carried along the cell chain
   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] hop;
      logic [PORT_W-1:0] port;
   } best_type;

endpackage

`default_nettype wire

// ----- hw/rtl/route_longest_prefix_match_core.sv -----
// lookup: the slot scan in each cell is followed by the merge down the cell chain;
//    each cell holds DEPTH = TABLE_ENTRIES / CELL_COUNT rounded up slots
// requests: a new request is not accepted until the current lookup has loaded its
//    response; one table write per cycle while no lookup is in progress
// reset: synchronous; clears control state and entries_in_use, table contents stay
`default_nettype none
`include "route_longest_prefix_match_core_defines.svh"

module route_longest_prefix_match_core #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int CELL_BITS     = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [rlpm_pkg::COUNT_W-1:0]   csr_wr_data,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic                           req_operation,
   input  wire logic [rlpm_pkg::INDEX_W-1:0]   req_entry_index,
   input  wire logic [rlpm_pkg::ADDR_W-1:0]    req_entry_prefix,
   input  wire logic [rlpm_pkg::ADDR_W-1:0]    req_entry_mask,
   input  wire logic [rlpm_pkg::ADDR_W-1:0]    req_entry_gateway,
   input  wire logic [rlpm_pkg::PORT_W-1:0]    req_entry_port,
   input  wire logic [rlpm_pkg::ADDR_W-1:0]    req_lookup_address,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic                           rsp_hit,
   output      logic [rlpm_pkg::ADDR_W-1:0]    rsp_gateway,
   output      logic [rlpm_pkg::PORT_W-1:0]    rsp_out_port,
   output      logic [rlpm_pkg::INDEX_W-1:0]   rsp_matched_index
);
   import rlpm_pkg::*;

   localparam int CELL_COUNT = 1 << CELL_BITS;
   localparam int DEPTH      = (TABLE_ENTRIES + CELL_COUNT - 1) >> CELL_BITS;
   localparam int SLOT_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W      = SLOT_W + CELL_BITS;
   localparam int WIDX_W     = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
   localparam int CNT_W      = $clog2(DEPTH + CELL_COUNT + 2);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] addr_in;
   logic [IDX_W:0]    limit_ff;
   logic [IDX_W:0]    limit_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_hit_ff;
   logic [ADDR_W-1:0]  rsp_hop_ff;
   logic [PORT_W-1:0]  rsp_port_ff;
   logic [INDEX_W-1:0] rsp_index_ff;

   logic               req_accept;
   logic               wr_hit;
   logic [WIDX_W-1:0]  wide_index;
   logic [CELL_BITS-1:0] wr_cell;
   logic [SLOT_W-1:0]  wr_slot;
   entry_type          wr_entry;
   logic               rd_en;
   logic               rd_first;
   logic [SLOT_W-1:0]  rd_slot;
   logic               rsp_free;
   logic               drain_done;
   logic               rsp_load;

   best_type           chain [CELL_COUNT+1];
   logic [IDX_W-1:0]   chain_idx [CELL_COUNT+1];
   best_type           result;

   // entries_in_use is kept already clipped to the table size
   assign limit_in = (32'(csr_wr_data) > 32'(TABLE_ENTRIES)) ? (IDX_W+1)'(TABLE_ENTRIES)
                                                              : (IDX_W+1)'(csr_wr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_wr_en) begin
         limit_ff <= limit_in;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // table writes go straight to the owning cell
   assign wr_hit     = req_accept && (req_operation == OP_WRITE) &&
                       (32'(req_entry_index) < 32'(TABLE_ENTRIES));
   assign wide_index = WIDX_W'(req_entry_index);
   assign wr_cell    = wide_index[CELL_BITS-1:0];
   assign wr_slot    = wide_index[CELL_BITS +: SLOT_W];
   assign wr_entry   = '{prefix: req_entry_prefix, mask: req_entry_mask,
                         hop: req_entry_gateway, port: req_entry_port};

   assign rd_en    = (state_ff == ST_SCAN);
   assign rd_slot  = cnt_ff[SLOT_W-1:0];
   assign rd_first = (cnt_ff == '0);

   assign chain[0]     = '0;
   assign chain_idx[0] = '0;

   for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
      rlpm_cell #(
         .SLOT_W    (SLOT_W),
         .CELL_BITS (CELL_BITS),
         .CELL_ID   (c),
         .DEPTH     (DEPTH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .wr_en         (wr_hit && (wr_cell == CELL_BITS'(c))),
         .wr_slot       (wr_slot),
         .wr_entry      (wr_entry),
         .rd_en         (rd_en),
         .rd_slot       (rd_slot),
         .rd_first      (rd_first),
         .lookup_addr   (addr_ff),
         .limit         (limit_ff),
         .chain_in      (chain[c]),
         .chain_in_idx  (chain_idx[c]),
         .chain_out     (chain[c+1]),
         .chain_out_idx (chain_idx[c+1])
      );
   end

   assign result = chain[CELL_COUNT];

   // drain ends once the last slot read has been compared and the result has passed every cell of the chain
   assign drain_done = (state_ff == ST_DRAIN) && (cnt_ff == CNT_W'(CELL_COUNT + 1));
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = drain_done && rsp_free;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      addr_in  = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_operation == OP_LOOKUP)) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
               addr_in  = req_lookup_address;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(DEPTH - 1)) begin
               state_in = ST_DRAIN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (drain_done) begin
               if (rsp_free) begin
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      addr_ff <= addr_in;
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // miss reports all fields as zero
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hit_ff   <= result.found;
         rsp_hop_ff   <= result.found ? result.hop : '0;
         rsp_port_ff  <= result.found ? result.port : '0;
         rsp_index_ff <= result.found ? INDEX_W'(chain_idx[CELL_COUNT]) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_gateway       = rsp_hop_ff;
   assign rsp_out_port      = rsp_port_ff;
   assign rsp_matched_index = rsp_index_ff;

   `RLPM_ASSERT_IMP(a_rsp_from_drain, $rose(rsp_valid_ff), $past(state_ff) == ST_DRAIN,
                    "response not produced by a finished lookup")
   `RLPM_ASSERT_IMP(a_miss_zero, rsp_valid_ff && !rsp_hit_ff,
                    (rsp_hop_ff == '0) && (rsp_port_ff == '0) && (rsp_index_ff == '0),
                    "miss response carries nonzero fields")
   `RLPM_ASSERT_IMP(a_scan_range, state_ff == ST_SCAN, 32'(cnt_ff) < 32'(DEPTH),
                    "scan slot beyond cell depth")
   `RLPM_ASSERT_NXT(a_write_stays_idle, req_accept && (req_operation == OP_WRITE),
                    state_ff == ST_IDLE, "table write started a lookup")

endmodule

`default_nettype wire

// ----- hw/rtl/rlpm_cell.sv -----
// one lookup cell: a slice of the route table, a local scan and a chain merge stage
`default_nettype none

module rlpm_cell #(
   parameter int SLOT_W    = 6,
   parameter int CELL_BITS = 4,
   parameter int CELL_ID   = 0,
   parameter int DEPTH     = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [SLOT_W-1:0]             wr_slot,
   input  wire rlpm_pkg::entry_type           wr_entry,
   input  wire logic                          rd_en,
   input  wire logic [SLOT_W-1:0]             rd_slot,
   input  wire logic                          rd_first,
   input  wire logic [rlpm_pkg::ADDR_W-1:0]   lookup_addr,
   input  wire logic [SLOT_W+CELL_BITS:0]     limit,
   input  wire rlpm_pkg::best_type            chain_in,
   input  wire logic [SLOT_W+CELL_BITS-1:0]   chain_in_idx,
   output      rlpm_pkg::best_type            chain_out,
   output      logic [SLOT_W+CELL_BITS-1:0]   chain_out_idx
);
   import rlpm_pkg::*;

   localparam int IDX_W = SLOT_W + CELL_BITS;

   entry_type entry_mem [DEPTH];

   entry_type         rd_data_ff;
   logic              rd_valid_ff;
   logic              rd_first_ff;
   logic [SLOT_W-1:0] rd_slot_ff;

   best_type          best_ff;
   best_type          best_in;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [IDX_W-1:0]  best_idx_in;

   best_type          chain_ff;
   best_type          chain_in_sel;
   logic [IDX_W-1:0]  chain_idx_ff;
   logic [IDX_W-1:0]  chain_idx_sel;

   logic [IDX_W-1:0]  rd_gidx;
   logic              in_use;
   logic              match;
   logic              take;
   logic              local_wins;

   // table slice, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_slot] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_slot];
      end
      rd_slot_ff <= rd_slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         rd_first_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
         rd_first_ff <= rd_first;
      end
   end

   // slots are interleaved: global index is slot then cell number
   assign rd_gidx = {rd_slot_ff, CELL_BITS'(CELL_ID)};
   assign in_use  = {1'b0, rd_gidx} < limit;
   assign match   = in_use && ((rd_data_ff.mask & lookup_addr) == rd_data_ff.prefix);
   // strictly longer only, so the lower slot keeps a tie
   assign take    = match && (rd_first_ff || !best_ff.found || (rd_data_ff.mask > best_ff.mask));

   always_comb begin
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (rd_valid_ff) begin
         if (take) begin
            best_in.found = 1'b1;
            best_in.mask  = rd_data_ff.mask;
            best_in.hop   = rd_data_ff.hop;
            best_in.port  = rd_data_ff.port;
            best_idx_in   = rd_gidx;
         end else if (rd_first_ff) begin
            best_in.found = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
      best_idx_ff <= best_idx_in;
   end

   // merge with the candidate handed over by the previous cell
   assign local_wins = best_ff.found &&
                       (!chain_in.found || (best_ff.mask > chain_in.mask) ||
                        ((best_ff.mask == chain_in.mask) && (best_idx_ff < chain_in_idx)));
   assign chain_in_sel  = local_wins ? best_ff : chain_in;
   assign chain_idx_sel = local_wins ? best_idx_ff : chain_in_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else begin
         chain_ff <= chain_in_sel;
      end
      chain_idx_ff <= chain_idx_sel;
   end

   assign chain_out     = chain_ff;
   assign chain_out_idx = chain_idx_ff;

endmodule

`default_nettype wire

// ----- tb/route_longest_prefix_match_core_test.sv -----
// self-checking testbench for the ipv4 longest-prefix-match route lookup core
`timescale 1ns / 1ps

module route_longest_prefix_match_core_test;
   import rlpm_pkg::*;

   localparam int TABLE_SLOTS   = 1024;
   localparam int SETTLE_CYCLES = 100;

   typedef struct packed {
      logic               hit;
      logic [ADDR_W-1:0]  gateway;
      logic [PORT_W-1:0]  out_port;
      logic [INDEX_W-1:0] matched_index;
   } route_result_type;

   typedef enum {ROW_SEND, ROW_COUNT} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic               op;
      logic [INDEX_W-1:0] index;
      logic [ADDR_W-1:0]  prefix;
      logic [ADDR_W-1:0]  mask;
      logic [ADDR_W-1:0]  hop;
      logic [PORT_W-1:0]  port;
      logic [ADDR_W-1:0]  addr;
      logic [COUNT_W-1:0] count;
      bit                 typed;
      route_result_type   exp;
   } plan_row_type;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;
   logic               req_valid;
   logic               req_stall;
   logic               req_operation;
   logic [INDEX_W-1:0] req_entry_index;
   logic [ADDR_W-1:0]  req_entry_prefix;
   logic [ADDR_W-1:0]  req_entry_mask;
   logic [ADDR_W-1:0]  req_entry_gateway;
   logic [PORT_W-1:0]  req_entry_port;
   logic [ADDR_W-1:0]  req_lookup_address;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_hit;
   logic [ADDR_W-1:0]  rsp_gateway;
   logic [PORT_W-1:0]  rsp_out_port;
   logic [INDEX_W-1:0] rsp_matched_index;

   // shadow of the routing table and the count register
   logic [ADDR_W-1:0]  prefix_tab [TABLE_SLOTS];
   logic [ADDR_W-1:0]  mask_tab [TABLE_SLOTS];
   logic [ADDR_W-1:0]  hop_tab [TABLE_SLOTS];
   logic [PORT_W-1:0]  port_tab [TABLE_SLOTS];
   bit                 written_tab [TABLE_SLOTS];
   logic [COUNT_W-1:0] route_count;

   route_result_type   pending_routes [$];
   int unsigned        errors;
   bit                 idle_on;

   route_longest_prefix_match_core #(
      .TABLE_ENTRIES(TABLE_SLOTS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_entry_index    (req_entry_index),
      .req_entry_prefix   (req_entry_prefix),
      .req_entry_mask     (req_entry_mask),
      .req_entry_gateway  (req_entry_gateway),
      .req_entry_port     (req_entry_port),
      .req_lookup_address (req_lookup_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_gateway        (rsp_gateway),
      .rsp_out_port       (rsp_out_port),
      .rsp_matched_index  (rsp_matched_index)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[route_longest_prefix_match_core] ERROR");
      $finish;
   end

   function automatic int unsigned pick_gap();
      return idle_on ? $urandom_range(0, 12) : 0;
   endfunction

   function automatic logic [ADDR_W-1:0] netmask(input int unsigned len);
      return (len == 0) ? '0 : (~32'h0 << (32 - len));
   endfunction

   function automatic int unsigned first_unwritten();
      int unsigned i;
      i = 0;
      while (i < TABLE_SLOTS && written_tab[i]) i++;
      return i;
   endfunction

   // longest mask wins, the first slot wins a tie
   function automatic route_result_type predict_lookup(input logic [ADDR_W-1:0] addr);
      route_result_type res;
      int unsigned   lim;
      logic [ADDR_W-1:0] best_mask;
      res = '0;
      best_mask = '0;
      lim = (route_count > TABLE_SLOTS) ? TABLE_SLOTS : route_count;
      for (int unsigned i = 0; i < lim; i++) begin
         if ((mask_tab[i] & addr) == prefix_tab[i] && (!res.hit || mask_tab[i] > best_mask)) begin
            best_mask = mask_tab[i];
            res.hit = 1'b1;
            res.gateway = hop_tab[i];
            res.out_port = port_tab[i];
            res.matched_index = INDEX_W'(i);
         end
      end
      return res;
   endfunction

   function automatic plan_row_type row_lookup(input logic [ADDR_W-1:0] addr);
      plan_row_type r;
      r.kind = ROW_SEND;
      r.op = OP_LOOKUP;
      r.index = INDEX_W'($urandom);
      r.prefix = $urandom;
      r.mask = $urandom;
      r.hop = $urandom;
      r.port = PORT_W'($urandom);
      r.addr = addr;
      r.count = '0;
      r.typed = 1'b0;
      r.exp = '0;
      return r;
   endfunction

   function automatic plan_row_type row_write(input int unsigned idx,
                                              input logic [ADDR_W-1:0] prefix,
                                              input logic [ADDR_W-1:0] mask,
                                              input logic [ADDR_W-1:0] hop,
                                              input int unsigned port);
      plan_row_type r;
      r = row_lookup($urandom);
      r.op = OP_WRITE;
      r.index = INDEX_W'(idx);
      r.prefix = prefix;
      r.mask = mask;
      r.hop = hop;
      r.port = PORT_W'(port);
      return r;
   endfunction

   function automatic plan_row_type row_expect(input logic [ADDR_W-1:0] addr, input bit hit,
                                               input logic [ADDR_W-1:0] hop,
                                               input int unsigned port,
                                               input int unsigned idx);
      plan_row_type r;
      r = row_lookup(addr);
      r.typed = 1'b1;
      r.exp = '{hit: hit, gateway: hop, out_port: PORT_W'(port), matched_index: INDEX_W'(idx)};
      return r;
   endfunction

   function automatic plan_row_type row_count(input int unsigned n);
      plan_row_type r;
      r = row_lookup('0);
      r.kind = ROW_COUNT;
      r.count = COUNT_W'(n);
      return r;
   endfunction

   // mostly well-formed routes and addresses that hit them, some noise
   function automatic plan_row_type random_row(input int unsigned span, input logic op);
      plan_row_type r;
      int unsigned fill, pick, j, lim;
      r = row_lookup($urandom);
      r.op = op;
      pick = $urandom_range(0, 9);
      if (op == OP_WRITE) begin
         fill = first_unwritten();
         r.index = (fill < span && $urandom_range(0, 2) != 0) ? INDEX_W'(fill)
                                                            : INDEX_W'($urandom_range(0, span - 1));
         if (pick < 7) begin
            r.mask = netmask($urandom_range(0, 32));
            r.prefix = r.prefix & r.mask;
         end else if (pick < 9) begin
            // same prefix as another slot to exercise ties
            j = $urandom_range(0, span - 1);
            if (written_tab[j]) begin
               r.prefix = prefix_tab[j];
               r.mask = mask_tab[j];
            end
         end else if ($urandom_range(0, 1) != 0) begin
            r.prefix = r.prefix & r.mask;
         end
      end else begin
         lim = (route_count > TABLE_SLOTS) ? TABLE_SLOTS : route_count;
         if (pick < 7 && lim > 0) begin
            j = $urandom_range(0, lim - 1);
            r.addr = prefix_tab[j] | (r.addr & ~mask_tab[j]);
         end else if (pick == 7) begin
            r.addr = ($urandom_range(0, 1) != 0) ? '1 : '0;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_route_result();
      route_result_type want;
      if (pending_routes.size() == 0) begin
         report_mismatch($sformatf("result with no lookup pending, index %0d", rsp_matched_index));
         return;
      end
      want = pending_routes.pop_front();
      if (rsp_hit !== want.hit)
         report_mismatch($sformatf("hit %b, expected %b", rsp_hit, want.hit));
      if (rsp_gateway !== want.gateway)
         report_mismatch($sformatf("gateway %h, expected %h", rsp_gateway, want.gateway));
      if (rsp_out_port !== want.out_port)
         report_mismatch($sformatf("out_port %0d, expected %0d", rsp_out_port, want.out_port));
      if (rsp_matched_index !== want.matched_index)
         report_mismatch($sformatf("matched_index %0d, expected %0d",
                                   rsp_matched_index, want.matched_index));
   endtask

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_request(input plan_row_type r);
      int unsigned n;
      n = pick_gap();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_operation <= r.op;
      req_entry_index <= r.index;
      req_entry_prefix <= r.prefix;
      req_entry_mask <= r.mask;
      req_entry_gateway <= r.hop;
      req_entry_port <= r.port;
      req_lookup_address <= r.addr;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (r.op == OP_LOOKUP) begin
         pending_routes.push_back(r.typed ? r.exp : predict_lookup(r.addr));
      end else if (r.index < TABLE_SLOTS) begin
         prefix_tab[r.index] = r.prefix;
         mask_tab[r.index] = r.mask;
         hop_tab[r.index] = r.hop;
         port_tab[r.index] = r.port;
         written_tab[r.index] = 1'b1;
      end
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_routes.size() != 0) @(negedge clock);
   endtask

   task automatic set_route_count(input logic [COUNT_W-1:0] n);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= n;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      route_count = n;
   endtask

   task automatic run_phase(input int unsigned count, input int unsigned span,
                            input int unsigned items);
      set_route_count(COUNT_W'(count));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (items) begin
         send_request(random_row(span, ($urandom_range(0, 9) < 6) ? OP_LOOKUP : OP_WRITE));
         // occasional hold-off until the pipeline is empty
         if ($urandom_range(0, 39) == 0) drain_results();
      end
   endtask

   // result side: sample at the rising edge, stall changes at the falling edge
   initial begin
      int unsigned hold;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            check_route_result();
            hold = pick_gap();
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      plan_row_type plan [$];
      plan_row_type r;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_valid = 1'b0;
      req_operation = OP_WRITE;
      req_entry_index = '0;
      req_entry_prefix = '0;
      req_entry_mask = '0;
      req_entry_gateway = '0;
      req_entry_port = '0;
      req_lookup_address = '0;
      route_count = '0;
      errors = 0;
      idle_on = 1'b1;

      // no routes in use after reset
      plan.push_back(row_expect(32'hFFFF_FFFF, 1'b0, 32'h0, 0, 0));
      // default route, nested prefixes, host route
      plan.push_back(row_write(0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 15));
      plan.push_back(row_write(1, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 1));
      plan.push_back(row_write(2, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 2));
      plan.push_back(row_write(3, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0A01_0201, 3));
      plan.push_back(row_write(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 4));
      // same prefix as slot 2, loses the tie
      plan.push_back(row_write(5, 32'h0A01_0000, 32'hFFFF_0000, 32'h0000_0000, 0));
      // non-contiguous mask
      plan.push_back(row_write(6, 32'hC000_A800, 32'hFF00_FF00, 32'hC0A8_0001, 6));
      // prefix bits outside the mask, never matches
      plan.push_back(row_write(7, 32'h0000_0001, 32'h0000_0000, 32'h0101_0101, 7));
      plan.push_back(row_count(8));
      plan.push_back(row_lookup(32'h0A01_0203));
      plan.push_back(row_lookup(32'h0A01_FFFF));
      plan.push_back(row_lookup(32'h0AFF_FFFF));
      plan.push_back(row_lookup(32'hFFFF_FFFF));
      plan.push_back(row_expect(32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 15, 0));
      plan.push_back(row_lookup(32'hC012_A834));
      plan.push_back(row_lookup(32'hFFFF_FFFE));
      plan.push_back(row_count(1));
      plan.push_back(row_expect(32'h0A01_0203, 1'b1, 32'hFFFF_FFFF, 15, 0));
      plan.push_back(row_count(0));
      plan.push_back(row_expect(32'h0000_0000, 1'b0, 32'h0, 0, 0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_COUNT) set_route_count(plan[i].count);
         else send_request(plan[i]);
      end

      // small tables that grow from slot 0
      for (int p = 0; p < 4; p++) begin
         run_phase((p % 2 == 0) ? first_unwritten() : $urandom_range(0, first_unwritten()),
                   16 << p, 20);
      end

      // fill every remaining slot, lookups mixed in
      set_route_count(COUNT_W'(first_unwritten()));
      idle_on = 1'b1;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (!written_tab[i]) begin
            r = random_row(TABLE_SLOTS, OP_WRITE);
            r.index = INDEX_W'(i);
            send_request(r);
            if ($urandom_range(0, 15) == 0) send_request(random_row(TABLE_SLOTS, OP_LOOKUP));
         end
      end

      run_phase(TABLE_SLOTS, TABLE_SLOTS, 25);
      // count above the table size behaves as a full table
      run_phase(2047, TABLE_SLOTS, 25);
      run_phase($urandom_range(0, TABLE_SLOTS), TABLE_SLOTS, 15);

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_routes.size() != 0)
         report_mismatch($sformatf("%0d lookups never answered", pending_routes.size()));
      if (errors == 0) begin
         $display("[route_longest_prefix_match_core] OK");
      end else begin
         $display("[route_longest_prefix_match_core] ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rlpm_pkg.sv
hw/rtl/rlpm_cell.sv
hw/rtl/route_longest_prefix_match_core.sv
tb/route_longest_prefix_match_core_test.sv
